/* src/vaft_pkg.sv */
// ============================================================================
// vaft_pkg
// Shared widths, types and the arctangent table for the vector angle block.
// ============================================================================
package vaft_pkg;

    // Field widths.
    localparam int COORD_BITS = 16;
    localparam int ANGLE_BITS = 16;
    localparam int ITERATIONS = 16;

    // Fraction bits kept below the coordinate magnitude inside the CORDIC.
    localparam int GUARD_BITS = 58 - COORD_BITS;

    // Magnitudes start below 2^58; CORDIC gain and the sqrt(2) of the
    // diagonal keep them below 2^60, so 62 signed bits never wrap.
    localparam int XY_W = 62;

    // Angle accumulator: signed, with room for the table sum overshoot.
    localparam int Z_W = ANGLE_BITS + 2;

    // Width of the per-cell shift amount.
    localparam int SHIFT_W = $clog2(ITERATIONS);

    // Stream word widths, padded to whole bytes.
    localparam int S_TDATA_W = ((4 * COORD_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W = ((ANGLE_BITS + 7) / 8) * 8;

    // Fixed angles.
    localparam logic signed [Z_W-1:0]    QUARTER_Z = Z_W'(1) <<< (ANGLE_BITS - 2);
    localparam logic [ANGLE_BITS-1:0]    HALF_A    = ANGLE_BITS'(1) << (ANGLE_BITS - 1);

    // atan(2^-i) as a fraction of a full turn, scaled by 2^32.
    localparam logic [31:0] ATAN_TURN32 [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    // Word handed from cell to cell.
    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic                   dx_pos;     // dx > 0
        logic                   dy_neg;     // dy < 0
        logic                   fixed;      // angle already known, skip rotation
        logic                   degenerate; // both points coincide
    } vaft_word_t;

    // Table entry i rounded half up to angle units.
    function automatic logic signed [Z_W-1:0] table_units(input int i);
        logic [33:0] t;
        int          sh;
        t  = 34'(ATAN_TURN32[i % 32]);
        sh = (ANGLE_BITS >= 32) ? 0 : 32 - ANGLE_BITS;
        if (sh > 0)
        begin
            t = (t + (34'd1 << (sh - 1))) >> sh;
        end
        return Z_W'(t);
    endfunction

endpackage

/* src/vector_angle_full_turn.sv */
// ============================================================================
// vector_angle_full_turn
// Direction from one point to another as a fraction of a full turn.
// ============================================================================
// Each input word carries two points; the result word carries the direction
// from the first to the second, counterclockwise from +x, in units of 1/65536
// of a turn, and a flag that is set (with angle 0) when the points coincide.
// One word is accepted per clock cycle unless a stalled output has filled the
// chain. A word passes one input fold stage, one register per CORDIC step in
// a chain of identical cells, and the output register. Every stage has its own
// valid bit, so a stalled output only holds words behind it while the chain
// is full and bubbles are squeezed out.
// ============================================================================
module vector_angle_full_turn
    import vaft_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // from_x [15:0], from_y [31:16], to_x [47:32], to_y [63:48]
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // angle [15:0]
    output logic [M_TDATA_W-1:0] m_tdata,
    // degenerate [0]
    output logic [0:0]           m_tuser
);

    logic                  valid_chain [ITERATIONS+1];
    logic                  ready_chain [ITERATIONS+1];
    vaft_word_t            data_chain  [ITERATIONS+1];
    logic [ANGLE_BITS-1:0] angle;
    logic                  degenerate;

    // Fold the difference vector into the first quadrant.
    vaft_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .from_x    (s_tdata[COORD_BITS-1:0]),
        .from_y    (s_tdata[2*COORD_BITS-1:COORD_BITS]),
        .to_x      (s_tdata[3*COORD_BITS-1:2*COORD_BITS]),
        .to_y      (s_tdata[4*COORD_BITS-1:3*COORD_BITS]),
        .out_valid (valid_chain[0]),
        .out_ready (ready_chain[0]),
        .out_data  (data_chain[0])
    );

    // Chain of CORDIC cells, one per step.
    for (genvar i = 0; i < ITERATIONS; i++)
    begin : g_cell
        vaft_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .shift      (SHIFT_W'(i)),
            .step_angle (table_units(i)),
            .in_valid   (valid_chain[i]),
            .in_ready   (ready_chain[i]),
            .in_data    (data_chain[i]),
            .out_valid  (valid_chain[i+1]),
            .out_ready  (ready_chain[i+1]),
            .out_data   (data_chain[i+1])
        );
    end

    // Clamp, place on the circle and hold for the output stream.
    vaft_place u_place (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (valid_chain[ITERATIONS]),
        .in_ready   (ready_chain[ITERATIONS]),
        .in_data    (data_chain[ITERATIONS]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .angle      (angle),
        .degenerate (degenerate)
    );

    assign m_tdata    = M_TDATA_W'(angle);
    assign m_tuser[0] = degenerate;

endmodule

/* src/vaft_prep.sv */
// ============================================================================
// vaft_prep
// Input stage: forms the difference vector, folds it into the first quadrant
// and settles the axis and coincident-point cases.
// ============================================================================
module vaft_prep
    import vaft_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [COORD_BITS-1:0] from_x,
    input  logic signed [COORD_BITS-1:0] from_y,
    input  logic signed [COORD_BITS-1:0] to_x,
    input  logic signed [COORD_BITS-1:0] to_y,
    output logic                         out_valid,
    input  logic                         out_ready,
    output vaft_word_t                   out_data
);

    logic signed [COORD_BITS:0] dx;
    logic signed [COORD_BITS:0] dy;
    logic [COORD_BITS-1:0]      a;
    logic [COORD_BITS-1:0]      b;
    logic                       valid_reg;
    vaft_word_t                 data_reg;
    vaft_word_t                 data_next;

    // Difference and magnitudes; |d| always fits in COORD_BITS bits.
    assign dx = (COORD_BITS + 1)'(to_x) - (COORD_BITS + 1)'(from_x);
    assign dy = (COORD_BITS + 1)'(to_y) - (COORD_BITS + 1)'(from_y);
    assign a  = COORD_BITS'((dx > 0) ? dx : -dx);
    assign b  = COORD_BITS'((dy >= 0) ? dy : -dy);

    // Starting word for the rotation chain.
    always_comb
    begin
        data_next.x          = XY_W'({a, {GUARD_BITS{1'b0}}});
        data_next.y          = XY_W'({b, {GUARD_BITS{1'b0}}});
        data_next.dx_pos     = (dx > 0);
        data_next.dy_neg     = (dy < 0);
        data_next.degenerate = (dx == 0) && (dy == 0);
        data_next.fixed      = (a == '0) || (b == '0);
        data_next.z          = (b != '0 && a == '0) ? QUARTER_Z : '0;
    end

    assign in_ready = !valid_reg || out_ready;

    // Stage register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

/* src/vaft_cell.sv */
// ============================================================================
// vaft_cell
// One CORDIC vectoring step with its own pipeline register; the shift and
// the table angle of the step come in as constants from the chain.
// ============================================================================
module vaft_cell
    import vaft_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [SHIFT_W-1:0]    shift,
    input  logic signed [Z_W-1:0] step_angle,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  vaft_word_t            in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output vaft_word_t            out_data
);

    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;
    logic                   valid_reg;
    vaft_word_t             data_reg;
    vaft_word_t             data_next;

    // Arithmetic shifts round toward minus infinity.
    assign xs = in_data.x >>> shift;
    assign ys = in_data.y >>> shift;

    // Rotate toward the x axis; a negative y turns back counterclockwise.
    always_comb
    begin
        data_next = in_data;
        if (!in_data.fixed)
        begin
            if (in_data.y < 0)
            begin
                data_next.x = in_data.x - ys;
                data_next.y = in_data.y + xs;
                data_next.z = in_data.z - step_angle;
            end
            else
            begin
                data_next.x = in_data.x + ys;
                data_next.y = in_data.y - xs;
                data_next.z = in_data.z + step_angle;
            end
        end
    end

    assign in_ready = !valid_reg || out_ready;

    // Stage register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

/* src/vaft_place.sv */
// ============================================================================
// vaft_place
// Output stage: clamps the first-quadrant angle and places it on the full
// circle by quadrant; holds the result word for the output stream.
// ============================================================================
module vaft_place
    import vaft_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  vaft_word_t            in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [ANGLE_BITS-1:0] angle,
    output logic                  degenerate
);

    logic signed [Z_W-1:0]  z_sat;
    logic [ANGLE_BITS-1:0]  z_u;
    logic [ANGLE_BITS-1:0]  angle_next;
    logic                   valid_reg;
    logic [ANGLE_BITS-1:0]  angle_reg;
    logic                   degenerate_reg;

    // Clamp to [0, quarter turn].
    always_comb
    begin
        if (in_data.z < 0)
        begin
            z_sat = '0;
        end
        else if (in_data.z > QUARTER_Z)
        begin
            z_sat = QUARTER_Z;
        end
        else
        begin
            z_sat = in_data.z;
        end
    end

    assign z_u = ANGLE_BITS'(z_sat);

    // Quadrant placement, all sums modulo a full turn.
    always_comb
    begin
        if (in_data.degenerate)
        begin
            angle_next = '0;
        end
        else if (in_data.dx_pos && !in_data.dy_neg)
        begin
            angle_next = z_u;
        end
        else if (!in_data.dy_neg)
        begin
            angle_next = HALF_A - z_u;
        end
        else if (!in_data.dx_pos)
        begin
            angle_next = HALF_A + z_u;
        end
        else
        begin
            angle_next = '0 - z_u;
        end
    end

    assign in_ready = !valid_reg || out_ready;

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            angle_reg      <= angle_next;
            degenerate_reg <= in_data.degenerate;
        end
    end

    assign out_valid  = valid_reg;
    assign angle      = angle_reg;
    assign degenerate = degenerate_reg;

endmodule
